### rtl/core/daac_pkg.sv
package daac_pkg;

  // Configuration register map, word index = paddr / 4
  localparam int unsigned CfgAddrW = 5;

  typedef enum logic [2:0] {
    REG_GAP_OPEN        = 3'd0,
    REG_GAP_EXTEND      = 3'd1,
    REG_LONG_GAP_OPEN   = 3'd2,
    REG_LONG_GAP_EXTEND = 3'd3,
    REG_MATCH_CAP       = 3'd4,
    REG_ALIGN_MODE      = 3'd5
  } cfg_reg_e;

  // Alignment modes (code 3 behaves as right-aligned)
  typedef enum logic [1:0] {
    MODE_SCORE_ONLY = 2'd0,
    MODE_LEFT       = 2'd1,
    MODE_RIGHT      = 2'd2,
    MODE_RIGHT_ALT  = 2'd3
  } align_mode_e;

  // Winning source of z, low three traceback bits
  typedef enum logic [2:0] {
    SRC_SCORE = 3'd0,
    SRC_X     = 3'd1,
    SRC_Y     = 3'd2,
    SRC_X2    = 3'd3,
    SRC_Y2    = 3'd4
  } src_e;

  // Continuation flag positions in the traceback byte
  localparam int unsigned DirContX  = 3;
  localparam int unsigned DirContY  = 4;
  localparam int unsigned DirContX2 = 5;
  localparam int unsigned DirContY2 = 6;

  // Reset values of the configuration registers
  localparam logic [6:0] GapOpenRst       = 7'd4;
  localparam logic [6:0] GapExtendRst     = 7'd2;
  localparam logic [6:0] LongGapOpenRst   = 7'd24;
  localparam logic [6:0] LongGapExtendRst = 7'd1;
  localparam logic [7:0] MatchCapRst      = 8'd2;

  // H bookkeeping that rides along the pipe
  typedef struct packed {
    logic [31:0] h_right;
    logic        h_right_valid;
    logic [31:0] h_up;
    logic        first_diag;
  } hctx_t;

  // Stage 1: registered inputs and the four gap candidates
  typedef struct packed {
    logic signed [7:0] s;
    logic signed [7:0] u;
    logic signed [7:0] v;
    logic signed [7:0] x;
    logic signed [7:0] y;
    logic signed [7:0] x2;
    logic signed [7:0] y2;
    logic signed [7:0] c_x;
    logic signed [7:0] c_y;
    logic signed [7:0] c_x2;
    logic signed [7:0] c_y2;
    hctx_t             hc;
  } st1_t;

  // Stage 2: capped z and its source
  typedef struct packed {
    logic signed [7:0] z;
    src_e              src;
    logic signed [7:0] u;
    logic signed [7:0] v;
    logic signed [7:0] x;
    logic signed [7:0] y;
    logic signed [7:0] x2;
    logic signed [7:0] y2;
    hctx_t             hc;
  } st2_t;

  // Stage 3: new differences and traceback byte
  typedef struct packed {
    logic [7:0] un;
    logic [7:0] vn;
    logic [7:0] xn;
    logic [7:0] yn;
    logic [7:0] x2n;
    logic [7:0] y2n;
    logic [6:0] dir;
    hctx_t      hc;
  } st3_t;

  // Stage 4: result item
  typedef struct packed {
    logic [31:0] h;
    logic [6:0]  dir;
    logic [7:0]  y2n;
    logic [7:0]  x2n;
    logic [7:0]  yn;
    logic [7:0]  xn;
    logic [7:0]  vn;
    logic [7:0]  un;
  } st4_t;

endpackage

### rtl/core/dual_affine_alignment_cell_top.sv
// Dual affine-gap alignment cell, difference form. Each item carries one band
// cell (score, neighbor differences, running H values); the block returns the
// new u/v/x/y/x2/y2 differences, a traceback byte and the new H. It accepts one
// item per clock unless a stalled output has backed the pipe up. There are four
// register stages; the edge that takes an item loads the first, and the item
// then moves through the second, third and fourth, whose register drives the
// output. Each stage's work sits in front of its register: candidate sums,
// max/cap of z, gap updates, H add. A stalled output backs the pipe up stage by stage; bubbles close up.
// Write the APB registers only while no item is in flight.
module dual_affine_alignment_cell_top
  import daac_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // Input stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // cell_score, u_prev, v_prev, x_prev, y_prev, x2_prev, y2_prev, h_right, h_up
  input  logic [119:0]        s_axis_tdata,
  // h_right_valid, first_diag
  input  logic [1:0]          s_axis_tuser,
  // Output stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // u_out, v_out, x_out, y_out, x2_out, y2_out, dir_bits, h_out, one zero pad bit
  output logic [87:0]         m_axis_tdata,
  // Configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  logic [6:0]  gap_open_q, gap_extend_q, long_gap_open_q, long_gap_extend_q;
  logic [7:0]  match_cap_q;
  logic [1:0]  align_mode_q;
  logic        cfg_wr;
  cfg_reg_e    cfg_idx;
  logic        trace_off, right_al;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = cfg_reg_e'(paddr[CfgAddrW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_open_q        <= GapOpenRst;
      gap_extend_q      <= GapExtendRst;
      long_gap_open_q   <= LongGapOpenRst;
      long_gap_extend_q <= LongGapExtendRst;
      match_cap_q       <= MatchCapRst;
      align_mode_q      <= MODE_SCORE_ONLY;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_GAP_OPEN:        gap_open_q        <= pwdata[6:0];
        REG_GAP_EXTEND:      gap_extend_q      <= pwdata[6:0];
        REG_LONG_GAP_OPEN:   long_gap_open_q   <= pwdata[6:0];
        REG_LONG_GAP_EXTEND: long_gap_extend_q <= pwdata[6:0];
        REG_MATCH_CAP:       match_cap_q       <= pwdata[7:0];
        REG_ALIGN_MODE:      align_mode_q      <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (cfg_idx)
      REG_GAP_OPEN:        prdata = {25'd0, gap_open_q};
      REG_GAP_EXTEND:      prdata = {25'd0, gap_extend_q};
      REG_LONG_GAP_OPEN:   prdata = {25'd0, long_gap_open_q};
      REG_LONG_GAP_EXTEND: prdata = {25'd0, long_gap_extend_q};
      REG_MATCH_CAP:       prdata = {24'd0, match_cap_q};
      REG_ALIGN_MODE:      prdata = {30'd0, align_mode_q};
      default:             prdata = 32'd0;
    endcase
  end

  assign trace_off = (align_mode_q == MODE_SCORE_ONLY);
  assign right_al  = align_mode_q[1];

  // ---------------------------------------------------------------------------
  // Stage handshake: a stage loads when it is empty or its successor moves
  logic v1_q, v2_q, v3_q, v4_q;
  logic v1_d, v2_d, v3_d, v4_d;
  logic rdy1, rdy2, rdy3, rdy4;
  logic ld1, ld2, ld3, ld4;

  assign rdy4 = !v4_q || m_axis_tready;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign s_axis_tready = rdy1;

  assign ld1 = rdy1 && s_axis_tvalid;
  assign ld2 = rdy2 && v1_q;
  assign ld3 = rdy3 && v2_q;
  assign ld4 = rdy4 && v3_q;

  assign v1_d = rdy1 ? s_axis_tvalid : v1_q;
  assign v2_d = rdy2 ? v1_q : v2_q;
  assign v3_d = rdy3 ? v2_q : v3_q;
  assign v4_d = rdy4 ? v3_q : v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
      v4_q <= v4_d;
    end
  end

  st1_t st1_q, st1_d;
  st2_t st2_q, st2_d;
  st3_t st3_q, st3_d;
  st4_t st4_q, st4_d;

  // ---------------------------------------------------------------------------
  // Stage 1: unpack, form the four 8-bit gap candidates
  always_comb begin
    st1_d.s  = s_axis_tdata[7:0];
    st1_d.u  = s_axis_tdata[15:8];
    st1_d.v  = s_axis_tdata[23:16];
    st1_d.x  = s_axis_tdata[31:24];
    st1_d.y  = s_axis_tdata[39:32];
    st1_d.x2 = s_axis_tdata[47:40];
    st1_d.y2 = s_axis_tdata[55:48];
    st1_d.hc.h_right       = s_axis_tdata[87:56];
    st1_d.hc.h_up          = s_axis_tdata[119:88];
    st1_d.hc.h_right_valid = s_axis_tuser[0];
    st1_d.hc.first_diag    = s_axis_tuser[1];
    st1_d.c_x  = st1_d.x  + st1_d.v;
    st1_d.c_y  = st1_d.y  + st1_d.u;
    st1_d.c_x2 = st1_d.x2 + st1_d.v;
    st1_d.c_y2 = st1_d.y2 + st1_d.u;
  end

  // ---------------------------------------------------------------------------
  // Stage 2: running max over score and candidates, then cap at match score
  logic signed [7:0] z_a, z_b, z_c, z_d;
  src_e              src_a, src_b, src_c, src_d;
  logic              tk_x, tk_y, tk_x2, tk_y2;

  always_comb begin
    tk_x  = right_al ? (st1_q.c_x >= st1_q.s) : (st1_q.c_x > st1_q.s);
    z_a   = tk_x ? st1_q.c_x : st1_q.s;
    src_a = tk_x ? SRC_X : SRC_SCORE;
    tk_y  = right_al ? (st1_q.c_y >= z_a) : (st1_q.c_y > z_a);
    z_b   = tk_y ? st1_q.c_y : z_a;
    src_b = tk_y ? SRC_Y : src_a;
    tk_x2 = right_al ? (st1_q.c_x2 >= z_b) : (st1_q.c_x2 > z_b);
    z_c   = tk_x2 ? st1_q.c_x2 : z_b;
    src_c = tk_x2 ? SRC_X2 : src_b;
    tk_y2 = right_al ? (st1_q.c_y2 >= z_c) : (st1_q.c_y2 > z_c);
    z_d   = tk_y2 ? st1_q.c_y2 : z_c;
    src_d = tk_y2 ? SRC_Y2 : src_c;

    st2_d.z   = (z_d > $signed(match_cap_q)) ? $signed(match_cap_q) : z_d;
    st2_d.src = src_d;
    st2_d.u   = st1_q.u;
    st2_d.v   = st1_q.v;
    st2_d.x   = st1_q.x;
    st2_d.y   = st1_q.y;
    st2_d.x2  = st1_q.x2;
    st2_d.y2  = st1_q.y2;
    st2_d.hc  = st1_q.hc;
  end

  // ---------------------------------------------------------------------------
  // Stage 3: new differences, gap clamps and continuation flags
  logic [7:0] q8, e8, q28, e28;
  logic [7:0] t_x, t_y, t_x2, t_y2;
  logic       c_x, c_y, c_x2, c_y2;

  assign q8  = {1'b0, gap_open_q};
  assign e8  = {1'b0, gap_extend_q};
  assign q28 = {1'b0, long_gap_open_q};
  assign e28 = {1'b0, long_gap_extend_q};

  always_comb begin
    t_x  = st2_q.x  + st2_q.v - st2_q.z + q8;
    t_y  = st2_q.y  + st2_q.u - st2_q.z + q8;
    t_x2 = st2_q.x2 + st2_q.v - st2_q.z + q28;
    t_y2 = st2_q.y2 + st2_q.u - st2_q.z + q28;

    // continue when non-negative (right) or strictly positive (left)
    c_x  = !t_x[7]  && (right_al || (t_x  != 8'd0));
    c_y  = !t_y[7]  && (right_al || (t_y  != 8'd0));
    c_x2 = !t_x2[7] && (right_al || (t_x2 != 8'd0));
    c_y2 = !t_y2[7] && (right_al || (t_y2 != 8'd0));

    st3_d.un  = st2_q.z - st2_q.v;
    st3_d.vn  = st2_q.z - st2_q.u;
    st3_d.xn  = (c_x  ? t_x  : 8'd0) - q8  - e8;
    st3_d.yn  = (c_y  ? t_y  : 8'd0) - q8  - e8;
    st3_d.x2n = (c_x2 ? t_x2 : 8'd0) - q28 - e28;
    st3_d.y2n = (c_y2 ? t_y2 : 8'd0) - q28 - e28;

    st3_d.dir                 = {4'd0, st2_q.src};
    st3_d.dir[DirContX]       = c_x;
    st3_d.dir[DirContY]       = c_y;
    st3_d.dir[DirContX2]      = c_x2;
    st3_d.dir[DirContY2]      = c_y2;
    if (trace_off) begin
      st3_d.dir = 7'd0;
    end
    st3_d.hc = st2_q.hc;
  end

  // ---------------------------------------------------------------------------
  // Stage 4: running H update
  logic [31:0] qe_neg, h_base, h_inc;

  always_comb begin
    qe_neg = 32'd0 - ({25'd0, gap_open_q} + {25'd0, gap_extend_q});
    if (st3_q.hc.first_diag) begin
      h_base = qe_neg;
      h_inc  = {{24{st3_q.vn[7]}}, st3_q.vn};
    end else if (st3_q.hc.h_right_valid) begin
      h_base = st3_q.hc.h_right;
      h_inc  = {{24{st3_q.vn[7]}}, st3_q.vn};
    end else begin
      h_base = st3_q.hc.h_up;
      h_inc  = {{24{st3_q.un[7]}}, st3_q.un};
    end
    st4_d.h   = h_base + h_inc;
    st4_d.dir = st3_q.dir;
    st4_d.un  = st3_q.un;
    st4_d.vn  = st3_q.vn;
    st4_d.xn  = st3_q.xn;
    st4_d.yn  = st3_q.yn;
    st4_d.x2n = st3_q.x2n;
    st4_d.y2n = st3_q.y2n;
  end

  // Payload registers, loaded only when their stage advances
  always_ff @(posedge clk_i) begin
    if (ld1) begin
      st1_q <= st1_d;
    end
    if (ld2) begin
      st2_q <= st2_d;
    end
    if (ld3) begin
      st3_q <= st3_d;
    end
    if (ld4) begin
      st4_q <= st4_d;
    end
  end

  assign m_axis_tvalid = v4_q;
  assign m_axis_tdata  = {1'b0, st4_q};

  // ---------------------------------------------------------------------------
  // Assertions
  a_src_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[50:48] <= SRC_Y2))
    else $error("traceback source code out of range");

  a_full_only_when_blocked : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (v1_q && v2_q && v3_q && v4_q && !m_axis_tready))
    else $error("input stalled while the pipe has room");

  a_accept_fills_s1 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> v1_q)
    else $error("accepted item not held in first stage");

  a_stage_moves : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && rdy4) |=> v4_q)
    else $error("stage three item dropped on its way out");

  a_pad_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[87] == 1'b0))
    else $error("output pad bit set");

endmodule

### bench/daac_cell_checker.sv
`timescale 1ns / 100ps

// Watches both streams and the register port, predicts each result item and
// compares it with what the cell returns.
module daac_cell_checker
  import daac_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [119:0]        s_axis_tdata,
  input  logic [1:0]          s_axis_tuser,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [87:0]         m_axis_tdata,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  input  logic                pready,
  output int                  errors_o,
  output int                  outstanding_o,
  output int                  checked_o
);

  typedef struct packed {
    logic [7:0]  un;
    logic [7:0]  vn;
    logic [7:0]  xn;
    logic [7:0]  yn;
    logic [7:0]  x2n;
    logic [7:0]  y2n;
    logic [6:0]  dir;
    logic [31:0] h;
  } cell_result_t;

  // Local copy of the register file
  logic [6:0]  open_pen;
  logic [6:0]  ext_pen;
  logic [6:0]  long_open_pen;
  logic [6:0]  long_ext_pen;
  logic [7:0]  z_cap;
  align_mode_e mode;

  cell_result_t expected_cells_q[$];

  // One gap update: returns {continue flag, new difference}
  function automatic logic [8:0] gap_update(logic signed [7:0] g, logic signed [7:0] d,
                                            logic signed [7:0] z, logic [6:0] pen_open,
                                            logic [6:0] pen_ext, logic right);
    logic signed [7:0] t;
    logic              cont;
    t = g + d - z + $signed({1'b0, pen_open});
    cont = right ? (t >= 8'sd0) : (t > 8'sd0);
    if (t < 8'sd0 || (!right && t == 8'sd0)) t = 8'sd0;
    t = t - $signed({1'b0, pen_open}) - $signed({1'b0, pen_ext});
    return {cont, t};
  endfunction

  // Full cell update for one input item under the current registers
  function automatic cell_result_t align_cell(logic [119:0] d, logic [1:0] flags);
    logic signed [7:0] s, u, v, x, y, x2, y2;
    logic signed [7:0] cx, cy, cx2, cy2, z;
    logic [31:0]       hr, hu;
    logic [8:0]        gx, gy, gx2, gy2;
    logic              right;
    src_e              src;
    cell_result_t      r;
    s  = d[7:0];
    u  = d[15:8];
    v  = d[23:16];
    x  = d[31:24];
    y  = d[39:32];
    x2 = d[47:40];
    y2 = d[55:48];
    hr = d[87:56];
    hu = d[119:88];
    right = (mode == MODE_RIGHT) || (mode == MODE_RIGHT_ALT);

    cx  = x + v;
    cy  = y + u;
    cx2 = x2 + v;
    cy2 = y2 + u;

    // Left-aligned keeps the earlier candidate on a tie, right-aligned the later
    z = s;
    src = SRC_SCORE;
    if (right ? (cx >= z) : (cx > z)) begin
      z = cx;
      src = SRC_X;
    end
    if (right ? (cy >= z) : (cy > z)) begin
      z = cy;
      src = SRC_Y;
    end
    if (right ? (cx2 >= z) : (cx2 > z)) begin
      z = cx2;
      src = SRC_X2;
    end
    if (right ? (cy2 >= z) : (cy2 > z)) begin
      z = cy2;
      src = SRC_Y2;
    end
    if (z > $signed(z_cap)) z = $signed(z_cap);

    r.un = z - v;
    r.vn = z - u;
    gx  = gap_update(x, v, z, open_pen, ext_pen, right);
    gy  = gap_update(y, u, z, open_pen, ext_pen, right);
    gx2 = gap_update(x2, v, z, long_open_pen, long_ext_pen, right);
    gy2 = gap_update(y2, u, z, long_open_pen, long_ext_pen, right);
    r.xn  = gx[7:0];
    r.yn  = gy[7:0];
    r.x2n = gx2[7:0];
    r.y2n = gy2[7:0];

    r.dir = '0;
    r.dir[2:0] = src;
    r.dir[DirContX]  = gx[8];
    r.dir[DirContY]  = gy[8];
    r.dir[DirContX2] = gx2[8];
    r.dir[DirContY2] = gy2[8];
    if (mode == MODE_SCORE_ONLY) r.dir = '0;

    // H: first anti-diagonal uses -(q+e) as base, else h_right or h_up
    if (flags[1]) begin
      r.h = 32'd0 - ({25'd0, open_pen} + {25'd0, ext_pen}) + {{24{r.vn[7]}}, r.vn};
    end else if (flags[0]) begin
      r.h = hr + {{24{r.vn[7]}}, r.vn};
    end else begin
      r.h = hu + {{24{r.un[7]}}, r.un};
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected %0h, got %0h", name, exp_val, act_val);
      errors_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    cell_result_t exp_cell;
    if (!rst_ni) begin
      open_pen      = GapOpenRst;
      ext_pen       = GapExtendRst;
      long_open_pen = LongGapOpenRst;
      long_ext_pen  = LongGapExtendRst;
      z_cap         = MatchCapRst;
      mode          = MODE_SCORE_ONLY;
      expected_cells_q.delete();
      errors_o      = 0;
      outstanding_o = 0;
      checked_o     = 0;
    end else begin
      // Register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_GAP_OPEN:        open_pen      = pwdata[6:0];
          REG_GAP_EXTEND:      ext_pen       = pwdata[6:0];
          REG_LONG_GAP_OPEN:   long_open_pen = pwdata[6:0];
          REG_LONG_GAP_EXTEND: long_ext_pen  = pwdata[6:0];
          REG_MATCH_CAP:       z_cap         = pwdata[7:0];
          REG_ALIGN_MODE:      mode          = align_mode_e'(pwdata[1:0]);
          default: ;
        endcase
      end

      // Result items against the oldest prediction
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_cells_q.size() == 0) begin
          $error("result item with no input pending: %h", m_axis_tdata);
          errors_o++;
        end else begin
          exp_cell = expected_cells_q.pop_front();
          check_field("u_out", exp_cell.un, m_axis_tdata[7:0]);
          check_field("v_out", exp_cell.vn, m_axis_tdata[15:8]);
          check_field("x_out", exp_cell.xn, m_axis_tdata[23:16]);
          check_field("y_out", exp_cell.yn, m_axis_tdata[31:24]);
          check_field("x2_out", exp_cell.x2n, m_axis_tdata[39:32]);
          check_field("y2_out", exp_cell.y2n, m_axis_tdata[47:40]);
          check_field("dir_bits", exp_cell.dir, m_axis_tdata[54:48]);
          check_field("h_out", exp_cell.h, m_axis_tdata[86:55]);
          check_field("pad", 32'd0, m_axis_tdata[87]);
          checked_o++;
        end
      end

      if (s_axis_tvalid && s_axis_tready) begin
        expected_cells_q.push_back(align_cell(s_axis_tdata, s_axis_tuser));
      end
      outstanding_o = expected_cells_q.size();
    end
  end

endmodule

### bench/dual_affine_alignment_cell_top_tb.sv
`timescale 1ns / 100ps

module dual_affine_alignment_cell_top_tb
  import daac_pkg::*;
;

  localparam int RandomPerSetting = 97;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [119:0]        s_axis_tdata;   // s, u, v, x, y, x2, y2, h_right, h_up
  logic [1:0]          s_axis_tuser;   // h_right_valid, first_diag
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [87:0]         m_axis_tdata;   // u, v, x, y, x2, y2, dir, h, pad
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  int errors;
  int outstanding;
  int checked;
  int burst_left;
  int settings_used;
  int cur_open;

  dual_affine_alignment_cell_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  daac_cell_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .errors_o      (errors),
    .outstanding_o (outstanding),
    .checked_o     (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop in case the pipe hangs
  initial begin
    #5_000_000;
    $display("dual_affine_alignment_cell_top_tb: done, errors");
    $finish;
  end

  // Receiver: phases of always-ready, coin-flip and mostly-stalled
  initial begin
    int phase_len;
    int kind;
    m_axis_tready = 1'b0;
    forever begin
      kind = $urandom_range(0, 2);
      phase_len = $urandom_range(10, 120);
      repeat (phase_len) begin
        @(negedge clk_i);
        case (kind)
          0: m_axis_tready = 1'b1;
          1: m_axis_tready = $urandom_range(0, 1);
          default: m_axis_tready = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // APB write: setup then access, held until pready
  task automatic write_reg(cfg_reg_e idx, int width, int val, bit noisy);
    logic [31:0] data;
    data = val & ((32'd1 << width) - 1);
    if (noisy) data = data | ($urandom << width);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = data;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Drain the pipe, then program every register
  task automatic load_setting(int q, int e, int q2, int e2, int cap, align_mode_e md,
                              bit noisy);
    s_axis_tvalid = 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
    write_reg(REG_GAP_OPEN, 7, q, noisy);
    write_reg(REG_GAP_EXTEND, 7, e, noisy);
    write_reg(REG_LONG_GAP_OPEN, 7, q2, noisy);
    write_reg(REG_LONG_GAP_EXTEND, 7, e2, noisy);
    write_reg(REG_MATCH_CAP, 8, cap, noisy);
    write_reg(REG_ALIGN_MODE, 2, md, noisy);
    cur_open = q & 8'h7f;
    settings_used++;
  endtask

  // One cell item; sender runs in bursts with gaps in between
  task automatic send_cell(int s, int u, int v, int x, int y, int x2, int y2,
                           logic [31:0] hr, int hr_ok, logic [31:0] hu, int first);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        s_axis_tvalid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {hu, hr, y2[7:0], x2[7:0], y[7:0], x[7:0], v[7:0], u[7:0], s[7:0]};
    s_axis_tuser  = {first[0], hr_ok[0]};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    burst_left--;
  endtask

  // Difference values: mostly small, some full range, some near -q so that
  // the gap term lands on zero
  function automatic int pick_diff();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) return $urandom_range(0, 16) - 8;
    if (pick < 8) return $urandom_range(0, 255);
    return $urandom_range(0, 6) - 3 - cur_open;
  endfunction

  function automatic logic [31:0] pick_h();
    case ($urandom_range(0, 9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Ties, gap terms at exactly zero, 8-bit wrap, single winners, first diagonal
  task automatic send_gap_cases();
    send_cell(0, 0, 0, 0, 0, 0, 0, 32'd10, 1, 32'd20, 0);
    send_cell(-5, -50, 1, 3, -50, -50, -50, 32'd0, 0, 32'h1234_5678, 0);
    send_cell(0, 0, 0, -4, -4, -24, -24, 32'hffff_fff0, 1, 32'd0, 0);
    send_cell(0, -100, 100, 100, -100, 0, 0, 32'h7fff_ffff, 1, 32'd0, 0);
    send_cell(-10, 0, -20, -20, -20, -20, 1, 32'd0, 0, 32'h8000_0000, 0);
    send_cell(-10, -20, 0, -1, -20, -1, -20, 32'd5, 1, 32'd7, 0);
    send_cell(3, 1, -1, 2, 2, 2, 2, 32'h5555_aaaa, 1, 32'd9, 1);
  endtask

  initial begin
    int q, e, q2, e2, cap;
    align_mode_e md;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    burst_left    = 0;
    settings_used = 1;
    cur_open      = GapOpenRst;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: reset registers (score only), full-scale fields and H wrap
    send_cell(0, 0, 0, 0, 0, 0, 0, 32'd100, 1, 32'd0, 0);
    send_cell(127, 127, 127, 127, 127, 127, 127, 32'h7fff_ffff, 1, 32'd0, 0);
    send_cell(-128, -128, -128, -128, -128, -128, -128, 32'd0, 0, 32'h8000_0000, 0);
    send_cell(-3, 4, -2, 1, 0, -7, 5, 32'd77, 0, 32'd33, 1);

    load_setting(GapOpenRst, GapExtendRst, LongGapOpenRst, LongGapExtendRst,
                 MatchCapRst, MODE_LEFT, 1'b0);
    send_gap_cases();
    load_setting(GapOpenRst, GapExtendRst, LongGapOpenRst, LongGapExtendRst,
                 MatchCapRst, MODE_RIGHT, 1'b0);
    send_gap_cases();
    load_setting(GapOpenRst, GapExtendRst, LongGapOpenRst, LongGapExtendRst,
                 MatchCapRst, MODE_RIGHT_ALT, 1'b0);
    send_cell(0, 0, 0, 0, 0, 0, 0, 32'd10, 1, 32'd20, 0);
    send_cell(0, 0, 0, -4, -4, -24, -24, 32'hffff_fff0, 1, 32'd0, 0);
    send_cell(-10, -20, 0, -1, -20, -1, -20, 32'd5, 1, 32'd7, 0);

    // Random: register extremes first, then random settings in every mode
    for (int phase = 0; phase < 7; phase++) begin
      q   = $urandom_range(0, 15);
      e   = $urandom_range(0, 7);
      q2  = $urandom_range(0, 40);
      e2  = $urandom_range(0, 7);
      cap = $urandom_range(0, 16) - 8;
      case (phase)
        0: load_setting(0, 0, 0, 0, 127, MODE_LEFT, 1'b0);
        1: load_setting(127, 127, 127, 127, -128, MODE_RIGHT, 1'b0);
        2: load_setting(q, e, q2, e2, cap, MODE_SCORE_ONLY, 1'b1);
        3: load_setting(q, e, q2, e2, cap, MODE_LEFT, 1'b1);
        4: load_setting(q, e, q2, e2, cap, MODE_RIGHT, 1'b1);
        5: load_setting($urandom_range(0, 127), $urandom_range(0, 127),
                        $urandom_range(0, 127), $urandom_range(0, 127),
                        $urandom_range(0, 255), MODE_RIGHT_ALT, 1'b1);
        default: begin
          md = ($urandom_range(0, 1) == 0) ? MODE_LEFT : MODE_RIGHT;
          load_setting(q, e, q2, e2, $urandom_range(0, 255), md, 1'b1);
        end
      endcase
      repeat (RandomPerSetting) begin
        send_cell(pick_diff(), pick_diff(), pick_diff(), pick_diff(), pick_diff(),
                  pick_diff(), pick_diff(), pick_h(), $urandom_range(0, 1), pick_h(),
                  ($urandom_range(0, 4) == 0));
      end
    end

    // Drain and let any stray item show up
    s_axis_tvalid = 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);

    $display("%0d cells compared under %0d register settings", checked, settings_used);
    $display("covering score-only, left, right and spare mode code, ties, caps and H wrap");
    if (errors == 0) begin
      $display("dual_affine_alignment_cell_top_tb: done, clean");
    end else begin
      $display("dual_affine_alignment_cell_top_tb: done, errors");
    end
    $finish;
  end

endmodule
